// ===== hw/rtl/traffic_light_phase_controller_macros.svh =====
// Assertion macros used by the traffic light phase controller core.
`ifndef TRAFFIC_LIGHT_PHASE_CONTROLLER_MACROS_SVH
`define TRAFFIC_LIGHT_PHASE_CONTROLLER_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TLPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next cycle.
`define TLPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tlpc_pkg.sv =====
// Types and constants of the traffic light phase controller.
package tlpc_pkg;

    typedef enum logic [2:0] {
        PH_VG   = 3'd0,
        PH_VA   = 3'd1,
        PH_HG   = 3'd2,
        PH_HA   = 3'd3,
        PH_RED  = 3'd4,
        PH_PED  = 3'd5,
        PH_RAIL = 3'd6
    } phase_e;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_CAR_V = 3'd1,
        ACT_CAR_H = 3'd2,
        ACT_PED   = 3'd3,
        ACT_MODE  = 3'd4,
        ACT_OVR   = 3'd5
    } action_e;

    typedef enum logic [1:0] {
        RS_IDLE  = 2'd0,
        RS_CLEAR = 2'd1,
        RS_AMBER = 2'd2,
        RS_SAFE  = 2'd3
    } rail_step_e;

    typedef enum logic [1:0] {
        LIGHT_GREEN = 2'd0,
        LIGHT_AMBER = 2'd1,
        LIGHT_RED   = 2'd2
    } light_e;

    typedef enum logic [1:0] {
        RPL_OK       = 2'd0,
        RPL_BAD_MODE = 2'd1,
        RPL_BAD_ROAD = 2'd2
    } reply_e;

    typedef enum logic [2:0] {
        REG_GREEN_V    = 3'd0,
        REG_GREEN_H    = 3'd1,
        REG_SENSOR_MAX = 3'd2,
        REG_AMBER      = 3'd3,
        REG_ALL_RED    = 3'd4,
        REG_CLEARANCE  = 3'd5,
        REG_CHECK      = 3'd6,
        REG_CROSSING   = 3'd7
    } cfg_idx_e;

    localparam logic MODE_FIXED  = 1'b0;
    localparam logic MODE_DEMAND = 1'b1;

    localparam logic [1:0] ROAD_NONE = 2'd0;
    localparam logic [1:0] ROAD_V    = 2'd1;
    localparam logic [1:0] ROAD_H    = 2'd2;
    localparam logic [1:0] ROAD_BAD  = 2'd3;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [7:0] RST_GREEN_V    = 8'd30;
    localparam logic [7:0] RST_GREEN_H    = 8'd20;
    localparam logic [7:0] RST_SENSOR_MAX = 8'd30;
    localparam logic [7:0] RST_AMBER      = 8'd4;
    localparam logic [7:0] RST_ALL_RED    = 8'd2;
    localparam logic [7:0] RST_CLEARANCE  = 8'd10;
    localparam logic [7:0] RST_CHECK      = 8'd10;
    localparam logic [7:0] RST_CROSSING   = 8'd8;

    typedef struct packed {
        logic [7:0] green_vertical_fixed;
        logic [7:0] green_horizontal_fixed;
        logic [7:0] green_sensor_max;
        logic [7:0] amber_time;
        logic [7:0] all_red_time;
        logic [7:0] clearance_time;
        logic [7:0] check_period;
        logic [7:0] crossing_time;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        rail_stop;
        logic [1:0]  requested_mode;
        logic [1:0]  requested_road;
        logic [15:0] requested_seconds;
    } item_t;

    typedef struct packed {
        light_e     vertical_light;
        light_e     horizontal_light;
        phase_e     phase_code;
        logic       mode_now;
        logic       pedestrian_waiting;
        logic [1:0] override_road;
        logic [7:0] override_left;
        reply_e     reply_code;
    } result_t;

    typedef struct packed {
        phase_e     phase;
        logic [7:0] phase_seconds;
        logic [7:0] check_seconds;
        rail_step_e rail_step;
        logic       horizontal_due;
        logic       operating_mode;
        logic       vertical_demand;
        logic       horizontal_demand;
        logic       crossing_demand;
        logic [1:0] override_direction;
        logic [7:0] override_count;
        logic       hold_active;
    } state_t;

endpackage

// ===== hw/rtl/traffic_light_phase_controller.sv =====
// Top level of the traffic light phase controller with stream and APB ports.
// Requests enter on the s_ stream: s_tuser carries the action (tick, car
// vertical, car horizontal, pedestrian, set mode, override), s_tdata the
// rail stop level and the mode, road and seconds arguments. Every request
// gives exactly one result on the m_ stream with both lights, the phase,
// the mode, the pedestrian flag, the override state and a reply code.
// A request is held in an input register and the next phase is worked out
// combinationally into the output register, from which the result leaves.
// One request is taken every cycle as long as the receiver keeps m_tready
// high; when m_tready is low the result waits in the output register and
// one more request is still taken into the input register before s_tready
// drops.
// The APB port sets the eight timing registers, in seconds, at byte
// addresses 0 to 28; write them only while no request is in flight.
// Reset returns to sensor mode with vertical green, no demands, no override
// and the rail sequence idle, and empties both registers.
module traffic_light_phase_controller
    import tlpc_pkg::*;
#(
    parameter int unsigned OVERRIDE_DEFAULT = 30,
    parameter int unsigned OVERRIDE_MAX     = 120
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // rail_stop[0], requested_mode[2:1], requested_road[4:3],
    // requested_seconds[20:5], zero[23:21]
    input  logic [23:0]           s_tdata,
    // action[2:0]
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // vertical_light[1:0], horizontal_light[3:2], phase_code[6:4], mode_now[7],
    // pedestrian_waiting[8], override_road[10:9], override_left[18:11],
    // reply_code[20:19], zero[23:21]
    output logic [23:0]           m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_result_reg;
    logic    out_valid_reg;
    logic    advance;

    tlpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlpc_core #(
        .OVERRIDE_DEFAULT (OVERRIDE_DEFAULT),
        .OVERRIDE_MAX     (OVERRIDE_MAX)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action            <= s_tuser;
            in_item_reg.rail_stop         <= s_tdata[0];
            in_item_reg.requested_mode    <= s_tdata[2:1];
            in_item_reg.requested_road    <= s_tdata[4:3];
            in_item_reg.requested_seconds <= s_tdata[20:5];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.reply_code,
                       out_result_reg.override_left,
                       out_result_reg.override_road,
                       out_result_reg.pedestrian_waiting,
                       out_result_reg.mode_now,
                       out_result_reg.phase_code,
                       out_result_reg.horizontal_light,
                       out_result_reg.vertical_light};

endmodule

// ===== hw/rtl/tlpc_regs.sv =====
// APB register file holding the phase timing settings.
module tlpc_regs
    import tlpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_idx_e idx;
    logic     wr_en;
    logic [7:0] rd_byte;

    assign pready = 1'b1;
    assign idx    = cfg_idx_e'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.green_vertical_fixed   <= RST_GREEN_V;
            cfg_reg.green_horizontal_fixed <= RST_GREEN_H;
            cfg_reg.green_sensor_max       <= RST_SENSOR_MAX;
            cfg_reg.amber_time             <= RST_AMBER;
            cfg_reg.all_red_time           <= RST_ALL_RED;
            cfg_reg.clearance_time         <= RST_CLEARANCE;
            cfg_reg.check_period           <= RST_CHECK;
            cfg_reg.crossing_time          <= RST_CROSSING;
        end else if (wr_en) begin
            case (idx)
                REG_GREEN_V:    cfg_reg.green_vertical_fixed   <= pwdata[7:0];
                REG_GREEN_H:    cfg_reg.green_horizontal_fixed <= pwdata[7:0];
                REG_SENSOR_MAX: cfg_reg.green_sensor_max       <= pwdata[7:0];
                REG_AMBER:      cfg_reg.amber_time             <= pwdata[7:0];
                REG_ALL_RED:    cfg_reg.all_red_time           <= pwdata[7:0];
                REG_CLEARANCE:  cfg_reg.clearance_time         <= pwdata[7:0];
                REG_CHECK:      cfg_reg.check_period           <= pwdata[7:0];
                REG_CROSSING:   cfg_reg.crossing_time          <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GREEN_V:    rd_byte = cfg_reg.green_vertical_fixed;
            REG_GREEN_H:    rd_byte = cfg_reg.green_horizontal_fixed;
            REG_SENSOR_MAX: rd_byte = cfg_reg.green_sensor_max;
            REG_AMBER:      rd_byte = cfg_reg.amber_time;
            REG_ALL_RED:    rd_byte = cfg_reg.all_red_time;
            REG_CLEARANCE:  rd_byte = cfg_reg.clearance_time;
            REG_CHECK:      rd_byte = cfg_reg.check_period;
            REG_CROSSING:   rd_byte = cfg_reg.crossing_time;
            default:        rd_byte = 8'd0;
        endcase
        prdata = {{(APB_DATA_W-8){1'b0}}, rd_byte};
    end

endmodule

// ===== hw/rtl/tlpc_core.sv =====
// Phase state registers and the next-state logic for one request.
`include "traffic_light_phase_controller_macros.svh"

module tlpc_core
    import tlpc_pkg::*;
#(
    parameter int unsigned OVERRIDE_DEFAULT = 30,
    parameter int unsigned OVERRIDE_MAX     = 120
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    state_t      state_reg;
    state_t      state_next;
    reply_e      reply;
    action_e     act;
    logic        tick;
    logic        go;
    phase_e      go_ph;
    logic        ent_v;
    logic        ent_h;
    logic        ended;
    logic        gv;
    logic [1:0]  mine;
    logic [7:0]  limit;
    logic [7:0]  bumped;
    logic [15:0] secs;

    always_comb begin
        state_next = state_reg;
        reply      = RPL_OK;
        act        = action_e'(item.action);
        tick       = (act == ACT_TICK);
        go         = 1'b0;
        go_ph      = PH_RED;
        ent_v      = 1'b0;
        ent_h      = 1'b0;
        ended      = 1'b0;
        gv         = (state_reg.phase == PH_VG);
        mine       = gv ? ROAD_V : ROAD_H;
        limit      = 8'd0;
        bumped     = (state_reg.phase_seconds == 8'hFF) ? 8'hFF
                                                        : state_reg.phase_seconds + 8'd1;
        secs       = item.requested_seconds;

        case (act)
            ACT_CAR_V: state_next.vertical_demand   = 1'b1;
            ACT_CAR_H: state_next.horizontal_demand = 1'b1;
            ACT_PED:   state_next.crossing_demand   = 1'b1;
            ACT_MODE: begin
                if (item.requested_mode[1] == 1'b0) begin
                    state_next.operating_mode = item.requested_mode[0];
                end else begin
                    reply = RPL_BAD_MODE;
                end
            end
            ACT_OVR: begin
                if (item.requested_road == ROAD_BAD) begin
                    reply = RPL_BAD_ROAD;
                end else begin
                    if (secs == 16'd0) begin
                        secs = 16'(OVERRIDE_DEFAULT);
                    end
                    if (secs > 16'(OVERRIDE_MAX)) begin
                        secs = 16'(OVERRIDE_MAX);
                    end
                    state_next.override_direction = item.requested_road;
                    state_next.override_count     = (item.requested_road == ROAD_NONE)
                                                    ? 8'd0 : secs[7:0];
                end
            end
            default: ;
        endcase

        if (state_reg.rail_step == RS_IDLE && item.rail_stop) begin
            case (state_reg.phase)
                PH_VG: begin
                    state_next.rail_step = RS_CLEAR;
                    go    = 1'b1;
                    go_ph = PH_VG;
                end
                PH_HG: begin
                    state_next.rail_step = RS_AMBER;
                    go    = 1'b1;
                    go_ph = PH_HA;
                end
                PH_RED, PH_PED: begin
                    go = 1'b1;
                    if (state_reg.horizontal_due) begin
                        state_next.rail_step = RS_CLEAR;
                        go_ph = PH_VG;
                    end else begin
                        state_next.rail_step = RS_SAFE;
                        go_ph = PH_RAIL;
                    end
                end
                default: begin
                    state_next.rail_step = RS_SAFE;
                    go    = 1'b1;
                    go_ph = PH_RAIL;
                end
            endcase
        end else if (state_reg.rail_step != RS_IDLE) begin
            if (state_reg.rail_step == RS_SAFE && state_reg.phase == PH_RAIL) begin
                if (!item.rail_stop) begin
                    go    = 1'b1;
                    go_ph = PH_RED;
                end
            end else if (tick) begin
                state_next.phase_seconds = bumped;
                if (state_reg.rail_step == RS_CLEAR) begin
                    if (bumped >= cfg.clearance_time) begin
                        state_next.rail_step = RS_AMBER;
                        go    = 1'b1;
                        go_ph = PH_VA;
                    end
                end else if (state_reg.rail_step == RS_AMBER) begin
                    if (bumped >= cfg.amber_time) begin
                        state_next.rail_step = RS_SAFE;
                        go    = 1'b1;
                        go_ph = PH_RAIL;
                    end
                end else if (bumped >= cfg.all_red_time) begin
                    if (item.rail_stop) begin
                        go    = 1'b1;
                        go_ph = PH_RAIL;
                    end else begin
                        state_next.rail_step = RS_IDLE;
                        ent_v = 1'b1;
                    end
                end
            end
        end else if (tick) begin
            case (state_reg.phase)
                PH_VG, PH_HG: begin
                    if (state_reg.hold_active) begin
                        if (state_next.override_direction != mine) begin
                            ended = 1'b1;
                        end else begin
                            if (state_next.override_count != 8'd0) begin
                                state_next.override_count = state_next.override_count - 8'd1;
                            end
                            if (state_next.override_count == 8'd0) begin
                                state_next.override_direction = ROAD_NONE;
                                ended = 1'b1;
                            end
                        end
                    end else begin
                        state_next.phase_seconds = bumped;
                        state_next.check_seconds = (state_reg.check_seconds == 8'hFF)
                                                   ? 8'hFF : state_reg.check_seconds + 8'd1;
                        if (state_next.override_direction != ROAD_NONE
                            && state_next.override_direction != mine) begin
                            ended = 1'b1;
                        end else begin
                            if (state_next.operating_mode == MODE_DEMAND
                                && state_next.check_seconds >= cfg.check_period) begin
                                state_next.check_seconds = 8'd0;
                                if ((gv ? state_next.horizontal_demand
                                        : state_next.vertical_demand)
                                    || state_next.crossing_demand) begin
                                    ended = 1'b1;
                                end
                            end
                            if (state_next.operating_mode == MODE_DEMAND) begin
                                limit = cfg.green_sensor_max;
                            end else begin
                                limit = gv ? cfg.green_vertical_fixed
                                           : cfg.green_horizontal_fixed;
                            end
                            if (bumped >= limit) begin
                                ended = 1'b1;
                            end
                        end
                    end
                    if (ended) begin
                        go    = 1'b1;
                        go_ph = gv ? PH_VA : PH_HA;
                    end
                end
                PH_VA, PH_HA: begin
                    state_next.phase_seconds = bumped;
                    if (bumped >= cfg.amber_time) begin
                        go    = 1'b1;
                        go_ph = PH_RED;
                    end
                end
                PH_RED, PH_PED: begin
                    state_next.phase_seconds = bumped;
                    if (state_reg.phase == PH_RED && bumped >= cfg.all_red_time
                        && state_next.override_direction == ROAD_NONE
                        && state_next.crossing_demand) begin
                        state_next.crossing_demand = 1'b0;
                        go    = 1'b1;
                        go_ph = PH_PED;
                    end else if ((state_reg.phase == PH_RED && bumped >= cfg.all_red_time)
                        || (state_reg.phase == PH_PED && bumped >= cfg.crossing_time)) begin
                        if (state_next.override_direction == ROAD_V) begin
                            state_next.horizontal_due = 1'b1;
                            ent_v = 1'b1;
                        end else if (state_next.override_direction == ROAD_H) begin
                            state_next.horizontal_due = 1'b0;
                            ent_h = 1'b1;
                        end else if (state_reg.horizontal_due) begin
                            state_next.horizontal_due = 1'b0;
                            ent_h = 1'b1;
                        end else begin
                            state_next.horizontal_due = 1'b1;
                            ent_v = 1'b1;
                        end
                    end
                end
                default: begin
                    go    = 1'b1;
                    go_ph = PH_RED;
                end
            endcase
        end

        if (go) begin
            state_next.phase         = go_ph;
            state_next.phase_seconds = 8'd0;
            state_next.check_seconds = 8'd0;
            state_next.hold_active   = 1'b0;
        end
        if (ent_v) begin
            state_next.phase           = PH_VG;
            state_next.phase_seconds   = 8'd0;
            state_next.check_seconds   = 8'd0;
            state_next.vertical_demand = 1'b0;
            state_next.hold_active     = (state_next.override_direction == ROAD_V);
        end
        if (ent_h) begin
            state_next.phase             = PH_HG;
            state_next.phase_seconds     = 8'd0;
            state_next.check_seconds     = 8'd0;
            state_next.horizontal_demand = 1'b0;
            state_next.hold_active       = (state_next.override_direction == ROAD_H);
        end

        result.vertical_light   = LIGHT_RED;
        result.horizontal_light = LIGHT_RED;
        case (state_next.phase)
            PH_VG:   result.vertical_light   = LIGHT_GREEN;
            PH_VA:   result.vertical_light   = LIGHT_AMBER;
            PH_HG:   result.horizontal_light = LIGHT_GREEN;
            PH_HA:   result.horizontal_light = LIGHT_AMBER;
            default: ;
        endcase
        result.phase_code         = state_next.phase;
        result.mode_now           = state_next.operating_mode;
        result.pedestrian_waiting = state_next.crossing_demand;
        result.override_road      = state_next.override_direction;
        result.override_left      = state_next.override_count;
        result.reply_code         = reply;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase              <= PH_VG;
            state_reg.phase_seconds      <= 8'd0;
            state_reg.check_seconds      <= 8'd0;
            state_reg.rail_step          <= RS_IDLE;
            state_reg.horizontal_due     <= 1'b1;
            state_reg.operating_mode     <= MODE_DEMAND;
            state_reg.vertical_demand    <= 1'b0;
            state_reg.horizontal_demand  <= 1'b0;
            state_reg.crossing_demand    <= 1'b0;
            state_reg.override_direction <= ROAD_NONE;
            state_reg.override_count     <= 8'd0;
            state_reg.hold_active        <= 1'b0;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

    `TLPC_ASSERT(a_hold_in_green, aclk, aresetn,
        !state_reg.hold_active || state_reg.phase == PH_VG || state_reg.phase == PH_HG,
        "Override hold is active outside a green phase.")
    `TLPC_ASSERT(a_rail_safe_in_sequence, aclk, aresetn,
        state_reg.rail_step != RS_IDLE || state_reg.phase != PH_RAIL,
        "Rail-safe phase reached with the rail sequence idle.")
    `TLPC_ASSERT(a_override_count_matches, aclk, aresetn,
        (state_reg.override_direction == ROAD_NONE) == (state_reg.override_count == 8'd0),
        "Override direction and remaining count disagree.")
    `TLPC_ASSERT_NEXT(a_state_holds_idle, aclk, aresetn, !step,
        $stable(state_reg), "Controller state changed without a request.")

endmodule

// ===== tb/sv/traffic_light_phase_controller_tb.sv =====
// Self-checking testbench of the traffic light phase controller with its own phase predictor.
`timescale 1ns / 100ps

module traffic_light_phase_controller_tb;
    import tlpc_pkg::*;

    localparam int unsigned OVR_DEFAULT = 30;
    localparam int unsigned OVR_MAX     = 120;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 235;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam logic [1:0] REQ_CONGESTION = {1'b0, MODE_FIXED};
    localparam logic [1:0] REQ_SENSOR     = {1'b0, MODE_DEMAND};
    localparam logic [1:0] REQ_BAD_TWO    = 2'd2;
    localparam logic [1:0] REQ_BAD_THREE  = 2'd3;

    typedef enum {TM_KEEP, TM_MIN, TM_MAX, TM_ZERO, TM_SHORT, TM_WIDE} timing_plan_e;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    item_t   requests_to_send[$];
    result_t signal_results_due[$];
    item_t   held_request;
    int      send_wait = 0;
    int      recv_wait = 0;
    int      send_idle_max = 12;
    int      recv_idle_max = 12;
    int      mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit      rail_on = 1'b0;

    timing_plan_e phase_plan [8] = '{TM_KEEP, TM_MIN, TM_SHORT, TM_MAX,
                                     TM_SHORT, TM_ZERO, TM_WIDE, TM_SHORT};

    // Predictor state of the controller.
    cfg_t       timing;
    phase_e     cur_phase;
    logic [7:0] phase_secs;
    logic [7:0] check_secs;
    rail_step_e rail_step;
    logic       h_next;
    logic       op_mode;
    logic       v_dem;
    logic       h_dem;
    logic       ped_dem;
    logic [1:0] ovr_dir;
    logic [7:0] ovr_cnt;
    logic       hold;

    always #6 aclk = ~aclk;

    traffic_light_phase_controller #(
        .OVERRIDE_DEFAULT(OVR_DEFAULT),
        .OVERRIDE_MAX(OVR_MAX)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic void start_phase(phase_e p);
        cur_phase = p;
        phase_secs = '0;
        check_secs = '0;
        hold = 1'b0;
    endfunction

    function automatic void reset_signal_model();
        timing = {RST_GREEN_V, RST_GREEN_H, RST_SENSOR_MAX, RST_AMBER,
                  RST_ALL_RED, RST_CLEARANCE, RST_CHECK, RST_CROSSING};
        rail_step = RS_IDLE;
        h_next = 1'b1;
        op_mode = MODE_DEMAND;
        v_dem = 1'b0;
        h_dem = 1'b0;
        ped_dem = 1'b0;
        ovr_dir = ROAD_NONE;
        ovr_cnt = '0;
        start_phase(PH_VG);
    endfunction

    function automatic void open_green(logic vert);
        start_phase(vert ? PH_VG : PH_HG);
        if (vert) begin
            v_dem = 1'b0;
        end else begin
            h_dem = 1'b0;
        end
        hold = (ovr_dir == (vert ? ROAD_V : ROAD_H));
    endfunction

    function automatic void pick_next_green();
        if (ovr_dir == ROAD_V) begin
            h_next = 1'b1;
            open_green(1'b1);
        end else if (ovr_dir == ROAD_H) begin
            h_next = 1'b0;
            open_green(1'b0);
        end else if (h_next) begin
            h_next = 1'b0;
            open_green(1'b0);
        end else begin
            h_next = 1'b1;
            open_green(1'b1);
        end
    endfunction

    function automatic void begin_preemption();
        case (cur_phase)
            PH_VG: begin
                rail_step = RS_CLEAR;
                start_phase(PH_VG);
            end
            PH_HG: begin
                rail_step = RS_AMBER;
                start_phase(PH_HA);
            end
            PH_RED, PH_PED: begin
                if (h_next) begin
                    rail_step = RS_CLEAR;
                    start_phase(PH_VG);
                end else begin
                    rail_step = RS_SAFE;
                    start_phase(PH_RAIL);
                end
            end
            default: begin
                rail_step = RS_SAFE;
                start_phase(PH_RAIL);
            end
        endcase
    endfunction

    function automatic void rail_update(logic rail, logic tick);
        if (rail_step == RS_SAFE && cur_phase == PH_RAIL) begin
            if (!rail) start_phase(PH_RED);
            return;
        end
        if (!tick) return;
        phase_secs = sat_inc(phase_secs);
        if (rail_step == RS_CLEAR) begin
            if (phase_secs >= timing.clearance_time) begin
                rail_step = RS_AMBER;
                start_phase(PH_VA);
            end
        end else if (rail_step == RS_AMBER) begin
            if (phase_secs >= timing.amber_time) begin
                rail_step = RS_SAFE;
                start_phase(PH_RAIL);
            end
        end else if (phase_secs >= timing.all_red_time) begin
            if (rail) begin
                start_phase(PH_RAIL);
            end else begin
                rail_step = RS_IDLE;
                open_green(1'b1);
            end
        end
    endfunction

    function automatic logic green_done(logic vert);
        logic [1:0] mine;
        logic [7:0] limit;
        mine = vert ? ROAD_V : ROAD_H;
        if (hold) begin
            if (ovr_dir != mine) return 1'b1;
            if (ovr_cnt != 8'd0) ovr_cnt = ovr_cnt - 8'd1;
            if (ovr_cnt == 8'd0) begin
                ovr_dir = ROAD_NONE;
                return 1'b1;
            end
            return 1'b0;
        end
        phase_secs = sat_inc(phase_secs);
        check_secs = sat_inc(check_secs);
        if (ovr_dir != ROAD_NONE && ovr_dir != mine) return 1'b1;
        if (op_mode == MODE_DEMAND && check_secs >= timing.check_period) begin
            check_secs = '0;
            if ((vert ? h_dem : v_dem) || ped_dem) return 1'b1;
        end
        if (op_mode == MODE_DEMAND) begin
            limit = timing.green_sensor_max;
        end else begin
            limit = vert ? timing.green_vertical_fixed : timing.green_horizontal_fixed;
        end
        return phase_secs >= limit;
    endfunction

    function automatic void tick_update();
        case (cur_phase)
            PH_VG: if (green_done(1'b1)) start_phase(PH_VA);
            PH_HG: if (green_done(1'b0)) start_phase(PH_HA);
            PH_VA, PH_HA: begin
                phase_secs = sat_inc(phase_secs);
                if (phase_secs >= timing.amber_time) start_phase(PH_RED);
            end
            PH_RED: begin
                phase_secs = sat_inc(phase_secs);
                if (phase_secs >= timing.all_red_time) begin
                    if (ovr_dir == ROAD_NONE && ped_dem) begin
                        ped_dem = 1'b0;
                        start_phase(PH_PED);
                    end else begin
                        pick_next_green();
                    end
                end
            end
            PH_PED: begin
                phase_secs = sat_inc(phase_secs);
                if (phase_secs >= timing.crossing_time) pick_next_green();
            end
            default: start_phase(PH_RED);
        endcase
    endfunction

    function automatic result_t next_signal_result(item_t rq);
        result_t     r;
        reply_e      reply;
        logic [15:0] secs;
        reply = RPL_OK;
        secs = rq.requested_seconds;
        case (rq.action)
            ACT_CAR_V: v_dem = 1'b1;
            ACT_CAR_H: h_dem = 1'b1;
            ACT_PED:   ped_dem = 1'b1;
            ACT_MODE: begin
                if (rq.requested_mode <= REQ_SENSOR) begin
                    op_mode = (rq.requested_mode == REQ_SENSOR);
                end else begin
                    reply = RPL_BAD_MODE;
                end
            end
            ACT_OVR: begin
                if (rq.requested_road == ROAD_BAD) begin
                    reply = RPL_BAD_ROAD;
                end else begin
                    if (secs == 16'd0) secs = 16'(OVR_DEFAULT);
                    if (secs > OVR_MAX) secs = 16'(OVR_MAX);
                    ovr_dir = rq.requested_road;
                    ovr_cnt = (rq.requested_road == ROAD_NONE) ? 8'd0 : secs[7:0];
                end
            end
            default: ;
        endcase

        if (rail_step == RS_IDLE && rq.rail_stop) begin
            begin_preemption();
        end else if (rail_step != RS_IDLE) begin
            rail_update(rq.rail_stop, rq.action == ACT_TICK);
        end else if (rq.action == ACT_TICK) begin
            tick_update();
        end

        r.vertical_light = LIGHT_RED;
        r.horizontal_light = LIGHT_RED;
        case (cur_phase)
            PH_VG:   r.vertical_light = LIGHT_GREEN;
            PH_VA:   r.vertical_light = LIGHT_AMBER;
            PH_HG:   r.horizontal_light = LIGHT_GREEN;
            PH_HA:   r.horizontal_light = LIGHT_AMBER;
            default: ;
        endcase
        r.phase_code = cur_phase;
        r.mode_now = op_mode;
        r.pedestrian_waiting = ped_dem;
        r.override_road = ovr_dir;
        r.override_left = ovr_cnt;
        r.reply_code = reply;
        return r;
    endfunction

    function automatic item_t make_request(logic [2:0] act, logic rail, logic [1:0] mode,
                                           logic [1:0] road, logic [15:0] secs);
        item_t rq;
        rq.action = act;
        rq.rail_stop = rail;
        rq.requested_mode = mode;
        rq.requested_road = road;
        rq.requested_seconds = secs;
        return rq;
    endfunction

    // Rail stop comes in episodes so that whole preemption sequences run.
    function automatic item_t random_request();
        item_t rq;
        int    pick;
        if (rail_on) begin
            rail_on = ($urandom_range(0, 14) != 0);
        end else begin
            rail_on = ($urandom_range(0, 79) == 0);
        end
        rq.rail_stop = rail_on;
        rq.requested_mode = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
                                                        : 2'($urandom_range(0, 1));
        rq.requested_road = ($urandom_range(0, 7) == 0) ? ROAD_BAD : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0:       rq.requested_seconds = '0;
            1:       rq.requested_seconds = 16'($urandom_range(1, 12));
            2:       rq.requested_seconds = 16'($urandom_range(118, 122));
            default: rq.requested_seconds = 16'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 62)      rq.action = ACT_TICK;
        else if (pick < 70) rq.action = ACT_CAR_V;
        else if (pick < 78) rq.action = ACT_CAR_H;
        else if (pick < 85) rq.action = ACT_PED;
        else if (pick < 91) rq.action = ACT_MODE;
        else if (pick < 98) rq.action = ACT_OVR;
        else                rq.action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
        return rq;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic apb_access(logic wr, cfg_idx_e idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_timing(timing_plan_e plan);
        logic [7:0]  v;
        logic [31:0] rd;
        for (int i = 0; i < 8; i++) begin
            case (plan)
                TM_MIN:   v = 8'd1;
                TM_MAX:   v = 8'd255;
                TM_ZERO:  v = 8'd0;
                TM_SHORT: v = 8'($urandom_range(1, 8));
                default:  v = 8'($urandom_range(1, 255));
            endcase
            apb_access(1'b1, cfg_idx_e'(i), {24'($urandom), v}, rd);
            timing[8*(7-i) +: 8] = v;
        end
        for (int i = 0; i < 8; i++) begin
            apb_access(1'b0, cfg_idx_e'(i), '0, rd);
            if (rd[7:0] != timing[8*(7-i) +: 8]) begin
                report_mismatch("register readback", rd[7:0], timing[8*(7-i) +: 8]);
            end
        end
    endtask

    task automatic wait_quiet();
        while (requests_to_send.size() != 0 || s_tvalid || signal_results_due.size() != 0)
            @(negedge aclk);
    endtask

    // Request driver: prediction happens at the edge where a request is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) signal_results_due.push_back(next_signal_result(held_request));
            if (s_tvalid && !s_tready) begin
            end else if (send_wait != 0) begin
                s_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (requests_to_send.size() != 0) begin
                held_request = requests_to_send.pop_front();
                s_tuser <= held_request.action;
                s_tdata <= {3'b000, held_request.requested_seconds, held_request.requested_road,
                            held_request.requested_mode, held_request.rail_stop};
                s_tvalid <= 1'b1;
                send_wait <= $urandom_range(0, send_idle_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure after each result.
    always @(posedge aclk) begin
        result_t want;
        int      stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait <= 0;
        end else begin
            stall = 0;
            if (m_tvalid && m_tready) begin
                stall = $urandom_range(0, recv_idle_max);
                if (signal_results_due.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata, 0);
                end else begin
                    want = signal_results_due.pop_front();
                    if (m_tdata[1:0] != want.vertical_light)
                        report_mismatch("vertical_light", m_tdata[1:0], want.vertical_light);
                    if (m_tdata[3:2] != want.horizontal_light)
                        report_mismatch("horizontal_light", m_tdata[3:2], want.horizontal_light);
                    if (m_tdata[6:4] != want.phase_code)
                        report_mismatch("phase_code", m_tdata[6:4], want.phase_code);
                    if (m_tdata[7] != want.mode_now)
                        report_mismatch("mode_now", m_tdata[7], want.mode_now);
                    if (m_tdata[8] != want.pedestrian_waiting)
                        report_mismatch("pedestrian_waiting", m_tdata[8], want.pedestrian_waiting);
                    if (m_tdata[10:9] != want.override_road)
                        report_mismatch("override_road", m_tdata[10:9], want.override_road);
                    if (m_tdata[18:11] != want.override_left)
                        report_mismatch("override_left", m_tdata[18:11], want.override_left);
                    if (m_tdata[20:19] != want.reply_code)
                        report_mismatch("reply_code", m_tdata[20:19], want.reply_code);
                end
            end
            if (recv_wait != 0) begin
                m_tready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end else if (stall != 0) begin
                m_tready <= 1'b0;
                recv_wait <= stall - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("traffic_light_phase_controller regression: fail");
        $finish;
    end

    initial begin
        reset_signal_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 8; p++) begin
            if (p != 0) begin
                wait_quiet();
                repeat (4) @(posedge aclk);
                load_timing(phase_plan[p]);
            end
            send_idle_max = (p % 3 == 1) ? 0 : 12;
            recv_idle_max = (p % 4 == 2) ? 0 : 12;
            if (p == 0) begin
                requests_to_send.push_back(make_request(ACT_TICK, 1'b0, REQ_BAD_THREE,
                                                        ROAD_BAD, 16'hFFFF));
                requests_to_send.push_back(make_request(ACT_CAR_H, 1'b0, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_PED, 1'b0, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_CAR_V, 1'b0, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_MODE, 1'b0, REQ_BAD_TWO,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_MODE, 1'b0, REQ_BAD_THREE,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_MODE, 1'b0, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_MODE, 1'b0, REQ_SENSOR,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_OVR, 1'b0, REQ_CONGESTION,
                                                        ROAD_BAD, 16'hFFFF));
                requests_to_send.push_back(make_request(ACT_OVR, 1'b0, REQ_CONGESTION,
                                                        ROAD_V, 16'h0000));
                requests_to_send.push_back(make_request(ACT_TICK, 1'b0, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_OVR, 1'b0, REQ_CONGESTION,
                                                        ROAD_H, 16'hFFFF));
                requests_to_send.push_back(make_request(ACT_TICK, 1'b0, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_OVR, 1'b0, REQ_CONGESTION,
                                                        ROAD_NONE, 16'd5));
                requests_to_send.push_back(make_request(ACT_OVR, 1'b0, REQ_CONGESTION,
                                                        ROAD_V, 16'd121));
                requests_to_send.push_back(make_request(ACT_OVR, 1'b0, REQ_CONGESTION,
                                                        ROAD_H, 16'd1));
                requests_to_send.push_back(make_request(ACT_SPARE_6, 1'b0, REQ_BAD_THREE,
                                                        ROAD_BAD, 16'hFFFF));
                requests_to_send.push_back(make_request(ACT_SPARE_7, 1'b0, REQ_BAD_THREE,
                                                        ROAD_BAD, 16'hFFFF));
                requests_to_send.push_back(make_request(ACT_TICK, 1'b1, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_TICK, 1'b1, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                requests_to_send.push_back(make_request(ACT_PED, 1'b1, REQ_CONGESTION,
                                                        ROAD_NONE, 16'h0000));
                for (int k = 0; k < 4; k++) begin
                    requests_to_send.push_back(make_request(ACT_TICK, 1'b0, REQ_CONGESTION,
                                                            ROAD_NONE, 16'h0000));
                end
            end
            for (int k = 0; k < PHASE_ITEMS; k++) requests_to_send.push_back(random_request());
        end

        wait_quiet();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("traffic_light_phase_controller regression: pass");
        end else begin
            $display("traffic_light_phase_controller regression: fail");
        end
        $finish;
    end

endmodule
